### rtl/core/rsqs_pkg.sv
// Shared types, register indexes and helpers for the rotated sprite quad setup block.
`timescale 1ns / 1ps

package rsqs_pkg;

  localparam logic [1:0] REG_TEX_W   = 2'd0;
  localparam logic [1:0] REG_TEX_H   = 2'd1;
  localparam logic [1:0] REG_TEX_VLD = 2'd2;

  // one sprite request
  typedef struct packed {
    logic signed [23:0] src_x;
    logic signed [23:0] src_y;
    logic signed [23:0] src_w;
    logic signed [23:0] src_h;
    logic signed [23:0] dst_x;
    logic signed [23:0] dst_y;
    logic signed [23:0] dst_w;
    logic signed [23:0] dst_h;
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_y;
    logic        [15:0] rotation;
    logic        [31:0] tint_rgba;
  } req_t;

  // one corner of the quad
  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] tex_u;
    logic signed [23:0] tex_v;
    logic        [31:0] color_rgba;
    logic        [1:0]  corner;
    logic               last;
  } vtx_t;

  // classified sprite handed from front to back
  typedef struct packed {
    logic signed [25:0] ex0;
    logic signed [25:0] ex1;
    logic signed [25:0] ey0;
    logic signed [25:0] ey1;
    logic signed [25:0] ul;
    logic signed [25:0] ur;
    logic signed [25:0] vt;
    logic signed [25:0] vb;
    logic signed [23:0] dst_x;
    logic signed [23:0] dst_y;
    logic        [31:0] tint;
    logic signed [18:0] sn;
    logic signed [18:0] cs;
  } job_t;

  // corner fields that ride alongside the texture divider
  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic        [31:0] color;
    logic        [1:0]  corner;
    logic               last;
  } tag_t;

  typedef struct packed {
    logic signed [25:0] eu;
    logic signed [25:0] ev;
    tag_t               tag;
  } tdiv_in_t;

  function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
    logic signed [23:0] r;
    if (v > 32'sd8388607) r = 24'sh7FFFFF;
    else if (v < -32'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

endpackage

### rtl/core/rsqs_front.sv
// Front end: takes requests, works out edges and the sine/cosine pair, queues jobs.
`timescale 1ns / 1ps

module rsqs_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  rsqs_pkg::req_t      req,
  input  logic                tex_ok,
  output logic                job_valid,
  input  logic                job_pop,
  output rsqs_pkg::job_t      job
);

  typedef struct packed {
    rsqs_pkg::job_t     j;
    logic        [1:0]  quad;
    logic        [16:0] t0;
    logic        [16:0] t1;
    logic        [16:0] x0;
    logic        [16:0] x1;
    logic        [16:0] a0;
    logic        [16:0] a1;
  } fs_t;

  fs_t f1, f2, f3, f4, f5;
  logic v1, v2, v3, v4, v5;
  logic [3:0] used;
  logic take;

  rsqs_pkg::job_t queue [0:7];
  logic [2:0] wp, rp;
  logic [3:0] qcnt;

  logic signed [25:0] sx, sy, sw, sh, ox, oy, pw, ph, swa, sy2;
  logic signed [18:0] s0, s1;
  rsqs_pkg::job_t push_job;
  fs_t f1_next, f2_next, f3_next, f4_next, f5_next;

  assign req_stall = used[3];
  assign take      = req_valid && !req_stall && tex_ok;

  always_comb begin
    sx  = 26'(req.src_x);
    sy  = 26'(req.src_y);
    sw  = 26'(req.src_w);
    sh  = 26'(req.src_h);
    ox  = 26'(req.origin_x);
    oy  = 26'(req.origin_y);
    pw  = 26'(req.dst_w);
    ph  = 26'(req.dst_h);
    swa = (sw < 0) ? -sw : sw;
    sy2 = (sh < 0) ? sy - sh : sy;
    f1_next            = '0;
    f1_next.j.ul       = (sw < 0) ? sx + swa : sx;
    f1_next.j.ur       = (sw < 0) ? sx : sx + swa;
    f1_next.j.vt       = sy2;
    f1_next.j.vb       = sy2 + sh;
    f1_next.j.ex0      = -ox;
    f1_next.j.ex1      = pw - ox;
    f1_next.j.ey0      = -oy;
    f1_next.j.ey1      = ph - oy;
    f1_next.j.dst_x    = req.dst_x;
    f1_next.j.dst_y    = req.dst_y;
    f1_next.j.tint     = req.tint_rgba;
    f1_next.quad       = req.rotation[15:14];
    f1_next.t0         = {1'b0, req.rotation[13:0], 2'b00};
    f1_next.t1         = 17'h10000 - {1'b0, req.rotation[13:0], 2'b00};
  end

  // quarter-wave polynomial, one product per stage
  always_comb begin
    f2_next    = f1;
    f2_next.x0 = 17'(({17'b0, f1.t0} * {17'b0, f1.t0}) >> 16);
    f2_next.x1 = 17'(({17'b0, f1.t1} * {17'b0, f1.t1}) >> 16);
    f3_next    = f2;
    f3_next.a0 = 17'd42047 - 17'((30'd4640 * {13'b0, f2.x0}) >> 16);
    f3_next.a1 = 17'd42047 - 17'((30'd4640 * {13'b0, f2.x1}) >> 16);
    f4_next    = f3;
    f4_next.a0 = 17'd102943 - 17'(({17'b0, f3.x0} * {17'b0, f3.a0}) >> 16);
    f4_next.a1 = 17'd102943 - 17'(({17'b0, f3.x1} * {17'b0, f3.a1}) >> 16);
    f5_next    = f4;
    f5_next.a0 = 17'(({17'b0, f4.t0} * {17'b0, f4.a0}) >> 16);
    f5_next.a1 = 17'(({17'b0, f4.t1} * {17'b0, f4.a1}) >> 16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
    f1 <= f1_next;
    f2 <= f2_next;
    f3 <= f3_next;
    f4 <= f4_next;
    f5 <= f5_next;
  end

  always_comb begin
    s0 = $signed({2'b00, f5.a0});
    s1 = $signed({2'b00, f5.a1});
    push_job = f5.j;
    case (f5.quad)
      2'd0: begin push_job.sn = s0;  push_job.cs = s1;  end
      2'd1: begin push_job.sn = s1;  push_job.cs = -s0; end
      2'd2: begin push_job.sn = -s0; push_job.cs = -s1; end
      2'd3: begin push_job.sn = -s1; push_job.cs = s0;  end
      default: begin push_job.sn = s0; push_job.cs = s1; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (v5) queue[wp] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      qcnt <= '0;
      used <= '0;
    end else begin
      if (v5) wp <= wp + 3'd1;
      if (job_pop) rp <= rp + 3'd1;
      qcnt <= qcnt + {3'b0, v5} - {3'b0, job_pop};
      used <= used + {3'b0, take} - {3'b0, job_pop};
    end
  end

  assign job_valid = (qcnt != 4'd0);
  assign job       = queue[rp];

endmodule

### rtl/core/rsqs_tdiv.sv
// Pipelined texture coordinate divider, u and v lanes side by side.
`timescale 1ns / 1ps

module rsqs_tdiv (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  rsqs_pkg::tdiv_in_t   din,
  input  logic [14:0]          tex_w,
  input  logic [14:0]          tex_h,
  output logic                 out_valid,
  output rsqs_pkg::vtx_t       dout
);

  typedef struct packed {
    logic [35:0] num;
    logic [15:0] rem;
    logic [22:0] q;
    logic        neg;
    logic        ovf;
  } dv_t;

  logic [15:0] dd_u, dd_v;
  dv_t su [0:23];
  dv_t sv [0:23];
  rsqs_pkg::tag_t tg [0:23];
  logic vl [0:23];

  // divisor is twice the size so the rounding half lands on an integer
  assign dd_u = {(tex_w == 15'd0) ? 15'd1 : tex_w, 1'b0};
  assign dd_v = {(tex_h == 15'd0) ? 15'd1 : tex_h, 1'b0};

  function automatic dv_t prep(input logic signed [25:0] e, input logic [15:0] dd);
    logic [25:0] mag;
    dv_t r;
    mag   = (e < 0) ? 26'(-e) : 26'(e);
    r.num = {1'b0, mag, 9'b0} + {21'b0, dd[15:1]};
    r.ovf = ({3'b0, r.num} >= {dd, 23'b0});
    r.rem = {3'b0, r.num[35:23]};
    r.q   = '0;
    r.neg = (e < 0);
    return r;
  endfunction

  function automatic dv_t step(input dv_t s, input logic [15:0] dd, input logic nb);
    logic [16:0] trial;
    dv_t r;
    r     = s;
    trial = {s.rem, nb};
    if (trial >= {1'b0, dd}) begin
      r.rem = 16'(trial - {1'b0, dd});
      r.q   = {s.q[21:0], 1'b1};
    end else begin
      r.rem = trial[15:0];
      r.q   = {s.q[21:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic signed [23:0] fin(input dv_t s);
    logic [23:0] qq;
    logic signed [23:0] r;
    qq = s.ovf ? 24'h800000 : {1'b0, s.q};
    if (!s.neg && s.ovf) r = 24'sh7FFFFF;
    else if (s.neg) r = $signed(-qq);
    else r = $signed(qq);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) vl[0] <= 1'b0;
    else vl[0] <= in_valid;
    su[0] <= prep(din.eu, dd_u);
    sv[0] <= prep(din.ev, dd_v);
    tg[0] <= din.tag;
  end

  for (genvar j = 1; j < 24; j++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) vl[j] <= 1'b0;
      else vl[j] <= vl[j-1];
      su[j] <= step(su[j-1], dd_u, su[j-1].num[23-j]);
      sv[j] <= step(sv[j-1], dd_v, sv[j-1].num[23-j]);
      tg[j] <= tg[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= vl[23];
    dout.pos_x      <= tg[23].pos_x;
    dout.pos_y      <= tg[23].pos_y;
    dout.color_rgba <= tg[23].color;
    dout.corner     <= tg[23].corner;
    dout.last       <= tg[23].last;
    dout.tex_u      <= fin(su[23]);
    dout.tex_v      <= fin(sv[23]);
  end

endmodule

### rtl/core/rsqs_back.sv
// Back end: steps through the four corners, rotates them and buffers the results.
`timescale 1ns / 1ps

module rsqs_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_pop,
  input  rsqs_pkg::job_t     job,
  input  logic [14:0]        tex_w,
  input  logic [14:0]        tex_h,
  output logic               vtx_valid,
  input  logic               vtx_stall,
  output rsqs_pkg::vtx_t     vtx
);

  logic [1:0] k;
  logic [5:0] used;
  logic issue, deliver;

  logic signed [25:0] ex, ey, eu, ev;

  // stage 1: products
  logic               b1v;
  logic signed [44:0] pxa, pxb, pya, pyb;
  logic signed [25:0] b1u, b1vv;
  logic signed [23:0] b1dx, b1dy;
  logic        [31:0] b1tint;
  logic        [1:0]  b1k;
  // stage 2: rounded offsets
  logic               b2v;
  logic signed [29:0] rx, ry;
  logic signed [25:0] b2u, b2vv;
  logic signed [23:0] b2dx, b2dy;
  logic        [31:0] b2tint;
  logic        [1:0]  b2k;
  // stage 3: positions
  logic               b3v;
  rsqs_pkg::tdiv_in_t b3;

  logic signed [45:0] sum_x, sum_y;

  logic               dv_valid;
  rsqs_pkg::vtx_t     dv_out;

  rsqs_pkg::vtx_t fifo [0:31];
  logic [4:0] wp, rp;
  logic [5:0] fcnt;

  // every issued corner holds a slot until it leaves, so the buffer never overflows
  assign issue   = job_valid && (used != 6'd32);
  assign job_pop = issue && (k == 2'd3);
  assign deliver = vtx_valid && !vtx_stall;

  always_comb begin
    ex = (k[1]) ? job.ex1 : job.ex0;
    ey = (k == 2'd1 || k == 2'd2) ? job.ey1 : job.ey0;
    eu = (k[1]) ? job.ur : job.ul;
    ev = (k == 2'd1 || k == 2'd2) ? job.vb : job.vt;
  end

  always_comb begin
    sum_x = 46'(pxa) - 46'(pxb) + 46'sd32768;
    sum_y = 46'(pya) + 46'(pyb) + 46'sd32768;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k    <= '0;
      used <= '0;
      b1v  <= 1'b0;
      b2v  <= 1'b0;
      b3v  <= 1'b0;
    end else begin
      if (issue) k <= k + 2'd1;
      used <= used + {5'b0, issue} - {5'b0, deliver};
      b1v  <= issue;
      b2v  <= b1v;
      b3v  <= b2v;
    end
    pxa    <= ex * job.cs;
    pxb    <= ey * job.sn;
    pya    <= ex * job.sn;
    pyb    <= ey * job.cs;
    b1u    <= eu;
    b1vv   <= ev;
    b1dx   <= job.dst_x;
    b1dy   <= job.dst_y;
    b1tint <= job.tint;
    b1k    <= k;

    rx     <= sum_x[45:16];
    ry     <= sum_y[45:16];
    b2u    <= b1u;
    b2vv   <= b1vv;
    b2dx   <= b1dx;
    b2dy   <= b1dy;
    b2tint <= b1tint;
    b2k    <= b1k;

    b3.eu         <= b2u;
    b3.ev         <= b2vv;
    b3.tag.pos_x  <= rsqs_pkg::sat24(32'(b2dx) + 32'(rx));
    b3.tag.pos_y  <= rsqs_pkg::sat24(32'(b2dy) + 32'(ry));
    b3.tag.color  <= b2tint;
    b3.tag.corner <= b2k;
    b3.tag.last   <= (b2k == 2'd3);
  end

  rsqs_tdiv u_tdiv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b3v),
    .din       (b3),
    .tex_w     (tex_w),
    .tex_h     (tex_h),
    .out_valid (dv_valid),
    .dout      (dv_out)
  );

  always_ff @(posedge clk) begin
    if (dv_valid) fifo[wp] <= dv_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fcnt <= '0;
    end else begin
      if (dv_valid) wp <= wp + 5'd1;
      if (deliver) rp <= rp + 5'd1;
      fcnt <= fcnt + {5'b0, dv_valid} - {5'b0, deliver};
    end
  end

  assign vtx_valid = (fcnt != 6'd0);
  assign vtx       = fifo[rp];

endmodule

### rtl/core/rotated_sprite_quad_setup.sv
// Top level of the rotated sprite quad setup block: texture registers and the two halves.
`timescale 1ns / 1ps

// Usage:
//   Requests enter on req/req_valid and are taken when req_stall is low. Each
//   request yields four corners on vtx/vtx_valid, in the order top-left,
//   bottom-left, bottom-right, top-right, the fourth with last set. A corner
//   leaves at an edge where vtx_valid is high and vtx_stall is low.
//   Texture registers are written through cfg_valid/cfg_ready/cfg_index/
//   cfg_data; the user must write them only while the block is idle, and
//   the block itself does not enforce this. cfg_ready is always high. With
//   texture_valid clear a request is taken and dropped without output. A
//   request passes five front stages for the edges and the sine polynomial,
//   the job queue, three rotation stages and a 25-stage texture divider. The
//   back end issues one corner per cycle while a job is queued and the
//   corner buffer has room. A stalled receiver fills a 32-entry corner
//   buffer; the back end stops issuing when it is full and the front queue
//   of eight requests then raises req_stall. Nothing is lost.
//   Reset (rst, synchronous) empties all queues and pipelines and sets the
//   texture size to 1x1 with no texture bound.

module rotated_sprite_quad_setup (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  rsqs_pkg::req_t   req,
  output logic             vtx_valid,
  input  logic             vtx_stall,
  output rsqs_pkg::vtx_t   vtx,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [14:0]      cfg_data
);

  logic [14:0] tex_w, tex_h;
  logic        tex_ok;

  logic           job_valid, job_pop;
  rsqs_pkg::job_t job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_w  <= 15'd1;
      tex_h  <= 15'd1;
      tex_ok <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rsqs_pkg::REG_TEX_W:   tex_w  <= cfg_data;
        rsqs_pkg::REG_TEX_H:   tex_h  <= cfg_data;
        rsqs_pkg::REG_TEX_VLD: tex_ok <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rsqs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .tex_ok    (tex_ok),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .job       (job)
  );

  rsqs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .job       (job),
    .tex_w     (tex_w),
    .tex_h     (tex_h),
    .vtx_valid (vtx_valid),
    .vtx_stall (vtx_stall),
    .vtx       (vtx)
  );

endmodule

### tb/rotated_sprite_quad_setup_tb.sv
// Self-checking testbench for the rotated sprite quad setup block.
`timescale 1ns / 1ps

module rotated_sprite_quad_setup_tb;
  import rsqs_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic vtx_valid;
  logic vtx_stall = 1'b0;
  vtx_t vtx;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_TEX_W;
  logic [14:0] cfg_data = '0;

  rotated_sprite_quad_setup i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .vtx_valid(vtx_valid), .vtx_stall(vtx_stall), .vtx(vtx),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // local copy of the texture registers
  logic [14:0] tex_w_q = 15'd1;
  logic [14:0] tex_h_q = 15'd1;
  logic        tex_vld_q = 1'b0;

  vtx_t corner_q[$];
  int   errors = 0;
  bit   quiet = 0;       // no idling in the closing stretch
  bit   hold_long = 0;   // receiver holds off for a long stretch

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint qsine(input longint t);
    longint x2, inner, inner2;
    x2 = (t * t) >>> 16;
    inner = 42047 - ((4640 * x2) >>> 16);
    inner2 = 102943 - ((x2 * inner) >>> 16);
    return (t * inner2) >>> 16;
  endfunction

  function automatic logic [23:0] clip24(input longint v);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  function automatic logic [23:0] tex_div(input longint e, input logic [14:0] size);
    longint d, m, q;
    d = (size == 0) ? 1 : size;
    m = (e < 0) ? -e : e;
    q = ((m << 8) * 2 + d) / (2 * d);
    return clip24((e < 0) ? -q : q);
  endfunction

  // works out the four corners of one sprite and queues them
  task automatic predict_quad(input req_t r);
    longint sx, sy, sw, sh, ox, oy, pw, ph, s0, s1, sn, cs, t, ul, ur, vt, vb, rx, ry;
    longint ex[4], ey[4], eu[4], ev[4];
    bit flip;
    vtx_t v;
    if (!tex_vld_q) return;
    sx = r.src_x; sy = r.src_y; sw = r.src_w; sh = r.src_h;
    ox = r.origin_x; oy = r.origin_y; pw = r.dst_w; ph = r.dst_h;
    flip = sw < 0;
    if (flip) sw = -sw;
    if (sh < 0) sy = sy - sh;
    t = longint'(r.rotation[13:0]) << 2;
    s0 = qsine(t);
    s1 = qsine(65536 - t);
    case (r.rotation[15:14])
      2'd0: begin sn = s0; cs = s1; end
      2'd1: begin sn = s1; cs = -s0; end
      2'd2: begin sn = -s0; cs = -s1; end
      default: begin sn = -s1; cs = s0; end
    endcase
    ul = flip ? sx + sw : sx;
    ur = flip ? sx : sx + sw;
    vt = sy; vb = sy + sh;
    ex = '{-ox, -ox, -ox + pw, -ox + pw};
    ey = '{-oy, -oy + ph, -oy + ph, -oy};
    eu = '{ul, ul, ur, ur};
    ev = '{vt, vb, vb, vt};
    for (int k = 0; k < 4; k++) begin
      rx = (ex[k] * cs - ey[k] * sn + 32768) >>> 16;
      ry = (ex[k] * sn + ey[k] * cs + 32768) >>> 16;
      v.pos_x = clip24(longint'(r.dst_x) + rx);
      v.pos_y = clip24(longint'(r.dst_y) + ry);
      v.tex_u = tex_div(eu[k], tex_w_q);
      v.tex_v = tex_div(ev[k], tex_h_q);
      v.color_rgba = r.tint_rgba;
      v.corner = k[1:0];
      v.last = (k == 3);
      corner_q.push_back(v);
    end
  endtask

  // receiver: random stall bursts, plus one long hold-off
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        vtx_stall <= 1'b1;
        repeat (300) @(posedge clk);
        vtx_stall <= 1'b0;
        hold_long = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 9);
        vtx_stall <= 1'b1;
        repeat (n) @(posedge clk);
        vtx_stall <= 1'b0;
      end
    end
  end

  // corner checker
  always @(posedge clk) begin
    vtx_t w;
    if (!rst && vtx_valid && !vtx_stall) begin
      if (corner_q.size() == 0) begin
        report("unexpected corner", vtx.color_rgba, 32'h0);
      end else begin
        w = corner_q.pop_front();
        if (vtx.pos_x !== w.pos_x) report("pos_x", vtx.pos_x, w.pos_x);
        if (vtx.pos_y !== w.pos_y) report("pos_y", vtx.pos_y, w.pos_y);
        if (vtx.tex_u !== w.tex_u) report("tex_u", vtx.tex_u, w.tex_u);
        if (vtx.tex_v !== w.tex_v) report("tex_v", vtx.tex_v, w.tex_v);
        if (vtx.color_rgba !== w.color_rgba) report("color", vtx.color_rgba, w.color_rgba);
        if (vtx.corner !== w.corner) report("corner", vtx.corner, w.corner);
        if (vtx.last !== w.last) report("last", vtx.last, w.last);
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TEX_W: tex_w_q = val;
      REG_TEX_H: tex_h_q = val;
      default: tex_vld_q = val[0];
    endcase
  endtask

  task automatic drain();
    while (corner_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // offers one request and holds it until taken
  task automatic send(input req_t r);
    int n;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 9);
      req_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    predict_quad(r);
  endtask

  function automatic logic [23:0] rnd24();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'(int'($urandom_range(0, 8192)) - 4096);
      3: return 24'(int'($urandom_range(0, 131072)) - 65536);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic req_t rnd_req();
    req_t r;
    r.src_x = rnd24(); r.src_y = rnd24(); r.src_w = rnd24(); r.src_h = rnd24();
    r.dst_x = rnd24(); r.dst_y = rnd24(); r.dst_w = rnd24(); r.dst_h = rnd24();
    r.origin_x = rnd24(); r.origin_y = rnd24();
    r.rotation = 16'($urandom);
    r.tint_rgba = $urandom;
    return r;
  endfunction

  typedef struct {
    req_t r;
    bit   typed;   // expected corner 0 written out below
    vtx_t c0;
  } row_t;

  row_t rows[$];

  function automatic req_t mk(input logic [23:0] sx, sy, sw, sh, dx, dy, dw, dh, ox, oy,
                              input logic [15:0] rot, input logic [31:0] tint);
    req_t r;
    r = '{sx, sy, sw, sh, dx, dy, dw, dh, ox, oy, rot, tint};
    return r;
  endfunction

  initial begin
    req_t r;
    row_t row;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no texture bound after reset: taken and dropped
    send(mk('0, '0, 24'h100, 24'h100, '0, '0, 24'h100, 24'h100, '0, '0, 16'h0, 32'h1));
    send(rnd_req());
    req_valid <= 1'b0;
    drain();

    write_reg(REG_TEX_W, 15'd256);
    write_reg(REG_TEX_H, 15'd256);
    write_reg(REG_TEX_VLD, 15'd1);

    // zero angle, unit square, full texture: corner 0 sits at dst, tex at origin
    row.r = mk('0, '0, 24'h10000, 24'h10000, 24'h1000, 24'h2000, 24'h100, 24'h100,
               '0, '0, 16'h0, 32'hDEADBEEF);
    row.typed = 1;
    row.c0 = '{24'h1000, 24'h2000, 24'h0, 24'h0, 32'hDEADBEEF, 2'd0, 1'b0};
    rows.push_back(row);
    row.typed = 0;
    // quadrant boundaries and the top angle
    row.r = mk(24'h100, 24'h200, 24'h800, 24'h800, '0, '0, 24'h1000, 24'h800,
               24'h80, 24'h40, 16'h4000, 32'h01020304); rows.push_back(row);
    row.r.rotation = 16'h8000; rows.push_back(row);
    row.r.rotation = 16'hC000; rows.push_back(row);
    row.r.rotation = 16'hFFFF; rows.push_back(row);
    row.r.rotation = 16'h0001; rows.push_back(row);
    row.r.rotation = 16'h2000; rows.push_back(row);
    // horizontal mirror and negative height
    row.r.src_w = -24'sd2048; rows.push_back(row);
    row.r.src_h = -24'sd1024; rows.push_back(row);
    // saturation of position and texture coordinate at both ends
    row.r = mk(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000,
               24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF, 16'h1234, 32'hFFFFFFFF);
    rows.push_back(row);
    row.r = mk(24'h800000, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF,
               24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 16'hFFFF, 32'h0);
    rows.push_back(row);
    row.r = '0; rows.push_back(row);
    row.r = '1; rows.push_back(row);

    foreach (rows[i]) begin
      send(rows[i].r);
      if (rows[i].typed && corner_q.size() >= 4 &&
          corner_q[corner_q.size() - 4] !== rows[i].c0) begin
        report($sformatf("typed corner of row %0d", i),
               corner_q[corner_q.size() - 4].color_rgba, rows[i].c0.color_rgba);
      end
    end
    req_valid <= 1'b0;
    drain();

    // a zero width and a height of 16384 in the size registers, a zero size counts as one
    write_reg(REG_TEX_W, 15'd0);
    write_reg(REG_TEX_H, 15'd16384);
    repeat (6) send(rnd_req());
    req_valid <= 1'b0;
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_TEX_W, (ph == 0) ? 15'd16384 : 15'($urandom_range(1, 16384)));
      write_reg(REG_TEX_H, (ph == 1) ? 15'd1 : 15'($urandom_range(1, 16384)));
      write_reg(REG_TEX_VLD, (ph == 2) ? 15'd0 : 15'd1);
      if (ph == 1) hold_long = 1;   // sender keeps offering while corners back up
      if (ph == 4) quiet = 1;
      for (int n = 0; n < 40; n++) begin
        send(rnd_req());
        if (n == 20 && ph == 3) begin
          req_valid <= 1'b0;
          while (corner_q.size() != 0) @(posedge clk);
        end
      end
      req_valid <= 1'b0;
      drain();
    end

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### files.f
rtl/core/rsqs_pkg.sv
rtl/core/rsqs_front.sv
rtl/core/rsqs_tdiv.sv
rtl/core/rsqs_back.sv
rtl/core/rotated_sprite_quad_setup.sv
tb/rotated_sprite_quad_setup_tb.sv
